### design/stramp_pkg.sv
// ----------------------------------------------------------------------------
// stramp_pkg
// Shared widths, reset values, codes and control/status types of the
// stepper trapezoid ramp profiler.
// ----------------------------------------------------------------------------
package stramp_pkg;

    localparam int STEP_BITS  = 24;
    localparam int DELAY_W    = 16;
    localparam int INC_W      = DELAY_W - 1;
    localparam int FULL_W     = 23;
    localparam int RATE_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    // Step magnitude, signed ramp index, ramp divisor and divider dividend.
    localparam int MAG_W  = STEP_BITS;
    localparam int IDX_W  = STEP_BITS + 1;
    localparam int DEN_W  = STEP_BITS + 2;
    localparam int PROD_W = STEP_BITS + RATE_W;
    localparam int CNT_W  = $clog2(PROD_W + 1);

    localparam logic [DELAY_W-1:0] RST_MIN_DELAY   = 16'd100;
    localparam logic [DELAY_W-1:0] RST_FIRST_DELAY = 16'd10000;
    localparam logic [FULL_W-1:0]  RST_FULL_STEPS  = 23'd100;
    localparam logic [RATE_W-1:0]  RST_ACCEL_RATE  = 16'd100;
    localparam logic [RATE_W-1:0]  RST_DECEL_RATE  = 16'd100;
    localparam logic [DELAY_W-1:0] ONE_STEP_DELAY  = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_DELAY   = 3'd0,
        CFG_FIRST_DELAY = 3'd1,
        CFG_FULL_STEPS  = 3'd2,
        CFG_ACCEL_RATE  = 3'd3,
        CFG_DECEL_RATE  = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_STOP  = 2'd0,
        PH_ACCEL = 2'd1,
        PH_RUN   = 2'd2,
        PH_DECEL = 2'd3
    } phase_t;

    typedef struct packed {
        logic accept;
        logic decode;
        logic start;
        logic mul;
        logic mul_len;
        logic div_go;
        logic lim;
        logic len_quot;
        logic clamp;
        logic setlen;
        logic step;
        logic ramp_end;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic is_event;
        logic mag_zero;
        logic mag_one;
        logic running;
        logic toggle_half;
        logic lim_fits;
        logic phase_ramp;
        logic div_busy;
    } dp_status_t;

endpackage

### design/stramp_div.sv
// ----------------------------------------------------------------------------
// stramp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stramp_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [stramp_pkg::PROD_W-1:0]  dividend,
    input  logic [stramp_pkg::DEN_W-1:0]   divisor,
    output logic                           busy,
    output logic [stramp_pkg::PROD_W-1:0]  quotient,
    output logic [stramp_pkg::DEN_W-1:0]   remainder
);
    import stramp_pkg::*;

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [PROD_W-1:0] quo_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  dvs_reg;
    logic [DEN_W:0]    trial;
    logic              fits;
    logic [DEN_W-1:0]  rem_next;

    // The partial remainder stays below the divisor, so both branches fit.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[PROD_W-1]};
        fits     = trial >= {1'b0, dvs_reg};
        rem_next = fits ? DEN_W'(trial - {1'b0, dvs_reg}) : trial[DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(PROD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[PROD_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### design/stramp_dp.sv
// ----------------------------------------------------------------------------
// stramp_dp
// Datapath: configuration, move state, ramp arithmetic and result register.
// ----------------------------------------------------------------------------
module stramp_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [stramp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [stramp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                              command,
    input  logic [stramp_pkg::MAG_W-1:0]      move_steps,
    input  stramp_pkg::dp_cmd_t               cmd,
    output stramp_pkg::dp_status_t            status,
    output logic [stramp_pkg::INC_W-1:0]      compare_increment,
    output logic                              direction,
    output logic [1:0]                        phase,
    output logic                              timer_enable,
    output logic                              pulse_done
);
    import stramp_pkg::*;

    // Configuration
    logic [DELAY_W-1:0] min_delay_reg;
    logic [DELAY_W-1:0] first_delay_reg;
    logic [FULL_W-1:0]  full_steps_reg;
    logic [RATE_W-1:0]  accel_rate_reg;
    logic [RATE_W-1:0]  decel_rate_reg;

    // Move state
    phase_t                   run_phase_reg;
    logic                     dir_reg;
    logic [DELAY_W-1:0]       delay_reg;
    logic [MAG_W-1:0]         steps_reg;
    logic signed [IDX_W-1:0]  ramp_reg;
    logic [DEN_W-1:0]         rem_reg;
    logic [MAG_W-1:0]         begin_reg;
    logic signed [IDX_W-1:0]  lenneg_reg;
    logic [DELAY_W-1:0]       last_reg;
    logic                     toggle_reg;
    logic                     running_reg;

    // Working registers
    logic               in_event_reg;
    logic [MAG_W-1:0]   mag_reg;
    logic               neg_reg;
    logic [INC_W-1:0]   inc_reg;
    logic               pulse_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [PROD_W-1:0]  len_wide_reg;
    logic [MAG_W-1:0]   len_reg;

    // Result register
    logic [INC_W-1:0]   out_inc_reg;
    logic               out_dir_reg;
    phase_t             out_phase_reg;
    logic               out_ten_reg;
    logic               out_pulse_reg;

    logic [MAG_W-1:0]        mag_in;
    logic [RATE_W-1:0]       accel_eff;
    logic [RATE_W-1:0]       decel_eff;
    logic [FULL_W-1:0]       full_eff;
    logic [RATE_W:0]         rate_sum;
    logic [MAG_W-1:0]        mul_x;
    logic [RATE_W-1:0]       mul_y;
    logic [PROD_W-1:0]       product;
    logic [PROD_W-1:0]       div_quot;
    logic [DEN_W-1:0]        div_rem;
    logic                    div_busy;
    logic [MAG_W-1:0]        lim_raw;
    logic [MAG_W-1:0]        lim_eff;
    logic [MAG_W-1:0]        len_clamp;
    logic signed [IDX_W-1:0] n_next;
    logic [DEN_W-1:0]        den_next;
    logic [PROD_W-1:0]       ramp_num;
    logic [DELAY_W-1:0]      ramp_delay;
    logic [MAG_W-1:0]        steps_inc;
    logic [DELAY_W-1:0]      start_delay;
    logic                    start_run;

    stramp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_go),
        .dividend  (prod_reg),
        .divisor   (den_reg),
        .busy      (div_busy),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_comb
    begin
        mag_in    = move_steps[MAG_W-1] ? MAG_W'(MAG_W'(0) - move_steps) : move_steps;
        accel_eff = (accel_rate_reg == '0) ? RATE_W'(1) : accel_rate_reg;
        decel_eff = (decel_rate_reg == '0) ? RATE_W'(1) : decel_rate_reg;
        full_eff  = (full_steps_reg == '0) ? FULL_W'(1) : full_steps_reg;
        rate_sum  = {1'b0, accel_eff} + {1'b0, decel_eff};
        mul_x     = cmd.mul_len ? MAG_W'(full_eff) : mag_reg;
        mul_y     = cmd.mul_len ? accel_eff : decel_eff;
        product   = PROD_W'(mul_x) * PROD_W'(mul_y);

        lim_raw = div_quot[MAG_W-1:0];
        lim_eff = (lim_raw == '0) ? MAG_W'(1) : lim_raw;

        if (len_wide_reg == '0)
        begin
            len_clamp = MAG_W'(1);
        end
        else if (len_wide_reg > PROD_W'(mag_reg))
        begin
            len_clamp = mag_reg;
        end
        else
        begin
            len_clamp = len_wide_reg[MAG_W-1:0];
        end

        // For a negative index, ~(4n) equals 4|n| - 1.
        n_next   = ramp_reg + IDX_W'(1);
        den_next = n_next[IDX_W-1] ? DEN_W'(~{n_next, 2'b00}) : DEN_W'({n_next, 2'b01});
        ramp_num = PROD_W'({delay_reg, 1'b0}) + PROD_W'(rem_reg);

        // Accelerating steps shrink the delay, decelerating steps grow it.
        ramp_delay = ramp_reg[IDX_W-1] ? delay_reg + div_quot[DELAY_W-1:0]
                                       : delay_reg - div_quot[DELAY_W-1:0];

        steps_inc   = steps_reg + MAG_W'(1);
        start_run   = first_delay_reg <= min_delay_reg;
        start_delay = start_run ? min_delay_reg : first_delay_reg;
    end

    always_comb
    begin
        status.is_event    = in_event_reg;
        status.mag_zero    = mag_reg == '0;
        status.mag_one     = mag_reg == MAG_W'(1);
        status.running     = running_reg;
        status.toggle_half = toggle_reg;
        status.lim_fits    = lim_eff <= MAG_W'(full_eff);
        status.phase_ramp  = (run_phase_reg == PH_ACCEL) || (run_phase_reg == PH_DECEL);
        status.div_busy    = div_busy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_delay_reg   <= RST_MIN_DELAY;
            first_delay_reg <= RST_FIRST_DELAY;
            full_steps_reg  <= RST_FULL_STEPS;
            accel_rate_reg  <= RST_ACCEL_RATE;
            decel_rate_reg  <= RST_DECEL_RATE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MIN_DELAY:   min_delay_reg   <= cfg_data[DELAY_W-1:0];
                CFG_FIRST_DELAY: first_delay_reg <= cfg_data[DELAY_W-1:0];
                CFG_FULL_STEPS:  full_steps_reg  <= cfg_data[FULL_W-1:0];
                CFG_ACCEL_RATE:  accel_rate_reg  <= cfg_data[RATE_W-1:0];
                CFG_DECEL_RATE:  decel_rate_reg  <= cfg_data[RATE_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_phase_reg <= PH_STOP;
            dir_reg       <= 1'b0;
            delay_reg     <= '0;
            steps_reg     <= '0;
            ramp_reg      <= '0;
            rem_reg       <= '0;
            begin_reg     <= '0;
            lenneg_reg    <= '0;
            last_reg      <= '0;
            toggle_reg    <= 1'b0;
            running_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.decode && in_event_reg && running_reg)
            begin
                toggle_reg <= ~toggle_reg;
            end

            if (cmd.start)
            begin
                dir_reg     <= neg_reg;
                steps_reg   <= '0;
                rem_reg     <= '0;
                toggle_reg  <= 1'b0;
                last_reg    <= min_delay_reg;
                running_reg <= 1'b1;
                if (mag_reg == MAG_W'(1))
                begin
                    run_phase_reg <= PH_DECEL;
                    ramp_reg      <= -IDX_W'(1);
                    delay_reg     <= ONE_STEP_DELAY;
                end
                else
                begin
                    run_phase_reg <= start_run ? PH_RUN : PH_ACCEL;
                    ramp_reg      <= '0;
                    delay_reg     <= start_delay;
                end
            end

            if (cmd.setlen)
            begin
                lenneg_reg <= IDX_W'(0) - IDX_W'(len_reg);
                begin_reg  <= mag_reg - len_reg;
            end

            if (cmd.step)
            begin
                case (run_phase_reg)
                    PH_ACCEL, PH_DECEL:
                    begin
                        steps_reg <= steps_inc;
                        ramp_reg  <= n_next;
                    end
                    PH_RUN:
                    begin
                        steps_reg <= steps_inc;
                        if (steps_inc >= begin_reg)
                        begin
                            ramp_reg      <= lenneg_reg;
                            delay_reg     <= last_reg;
                            run_phase_reg <= PH_DECEL;
                        end
                        else
                        begin
                            delay_reg <= min_delay_reg;
                        end
                    end
                    default:
                    begin
                        steps_reg <= '0;
                        rem_reg   <= '0;
                        delay_reg <= '0;
                    end
                endcase
            end

            if (cmd.ramp_end)
            begin
                if (run_phase_reg == PH_ACCEL)
                begin
                    if (steps_reg >= begin_reg)
                    begin
                        rem_reg       <= div_rem;
                        ramp_reg      <= lenneg_reg;
                        run_phase_reg <= PH_DECEL;
                        delay_reg     <= ramp_delay;
                    end
                    else if (ramp_delay <= min_delay_reg)
                    begin
                        last_reg      <= ramp_delay;
                        delay_reg     <= min_delay_reg;
                        rem_reg       <= '0;
                        run_phase_reg <= PH_RUN;
                    end
                    else
                    begin
                        rem_reg   <= div_rem;
                        delay_reg <= ramp_delay;
                    end
                end
                else
                begin
                    rem_reg   <= div_rem;
                    delay_reg <= ramp_delay;
                    // The last decelerating step brings the index up to zero.
                    if (!ramp_reg[IDX_W-1])
                    begin
                        run_phase_reg <= PH_STOP;
                        running_reg   <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            in_event_reg <= command;
            mag_reg      <= mag_in;
            neg_reg      <= move_steps[MAG_W-1];
        end

        if (cmd.decode)
        begin
            inc_reg   <= delay_reg[DELAY_W-1:1];
            pulse_reg <= in_event_reg && running_reg && toggle_reg;
        end

        if (cmd.start)
        begin
            inc_reg <= (mag_reg == MAG_W'(1)) ? ONE_STEP_DELAY[DELAY_W-1:1]
                                              : start_delay[DELAY_W-1:1];
        end

        if (cmd.mul)
        begin
            prod_reg <= product;
            den_reg  <= cmd.mul_len ? DEN_W'(decel_eff) : DEN_W'(rate_sum);
        end

        if (cmd.step)
        begin
            prod_reg <= ramp_num;
            den_reg  <= den_next;
        end

        if (cmd.lim)
        begin
            len_wide_reg <= PROD_W'(mag_reg - lim_eff);
        end

        if (cmd.len_quot)
        begin
            len_wide_reg <= div_quot;
        end

        if (cmd.clamp)
        begin
            len_reg <= len_clamp;
        end

        if (cmd.out_load)
        begin
            out_inc_reg   <= inc_reg;
            out_dir_reg   <= dir_reg;
            out_phase_reg <= run_phase_reg;
            out_ten_reg   <= running_reg;
            out_pulse_reg <= pulse_reg;
        end
    end

    assign compare_increment = out_inc_reg;
    assign direction         = out_dir_reg;
    assign phase             = out_phase_reg;
    assign timer_enable      = out_ten_reg;
    assign pulse_done        = out_pulse_reg;

endmodule

### design/stramp_ctrl.sv
// ----------------------------------------------------------------------------
// stramp_ctrl
// Sequencer: walks each item through decode, setup arithmetic or one ramp
// step, and hands the result to the output register.
// ----------------------------------------------------------------------------
module stramp_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  stramp_pkg::dp_status_t status,
    output stramp_pkg::dp_cmd_t    cmd
);
    import stramp_pkg::*;

    typedef enum logic [17:0] {
        S_IDLE   = 18'h00001,
        S_DECODE = 18'h00002,
        S_START  = 18'h00004,
        S_MUL1   = 18'h00008,
        S_DGO1   = 18'h00010,
        S_DIV1   = 18'h00020,
        S_LIM    = 18'h00040,
        S_MUL2   = 18'h00080,
        S_DGO2   = 18'h00100,
        S_DIV2   = 18'h00200,
        S_LEN2   = 18'h00400,
        S_CLAMP  = 18'h00800,
        S_SETLEN = 18'h01000,
        S_STEP   = 18'h02000,
        S_DGOR   = 18'h04000,
        S_DIVR   = 18'h08000,
        S_REND   = 18'h10000,
        S_OUT    = 18'h20000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                if (!status.is_event && !status.mag_zero)
                begin
                    state_next = S_START;
                end
                else if (status.is_event && status.running && status.toggle_half)
                begin
                    state_next = S_STEP;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_START:
            begin
                cmd.start  = 1'b1;
                state_next = status.mag_one ? S_OUT : S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DGO1;
            end
            S_DGO1:
            begin
                cmd.div_go = 1'b1;
                state_next = S_DIV1;
            end
            S_DIV1:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_LIM;
                end
            end
            S_LIM:
            begin
                cmd.lim    = 1'b1;
                state_next = status.lim_fits ? S_CLAMP : S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul     = 1'b1;
                cmd.mul_len = 1'b1;
                state_next  = S_DGO2;
            end
            S_DGO2:
            begin
                cmd.div_go = 1'b1;
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_LEN2;
                end
            end
            S_LEN2:
            begin
                cmd.len_quot = 1'b1;
                state_next   = S_CLAMP;
            end
            S_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = S_SETLEN;
            end
            S_SETLEN:
            begin
                cmd.setlen = 1'b1;
                state_next = S_OUT;
            end
            S_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = status.phase_ramp ? S_DGOR : S_OUT;
            end
            S_DGOR:
            begin
                cmd.div_go = 1'b1;
                state_next = S_DIVR;
            end
            S_DIVR:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_REND;
                end
            end
            S_REND:
            begin
                cmd.ramp_end = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                // The result register takes the item once its previous item is gone.
                cmd.out_load = !out_valid_reg || out_ready;
                if (cmd.out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;

endmodule

### design/stepper_trapezoid_ramp.sv
// ----------------------------------------------------------------------------
// stepper_trapezoid_ramp
// Stepper move profiler with a linear speed ramp and remainder carry.
// Ignored items, half-step events, run-phase steps and one-step starts
// need no division; an accelerating or decelerating step uses the
// bit-serial divider once, and a longer start uses it once or twice.
// One item at a time; the next item is accepted once the result is
// registered, while that result may still wait for the consumer.
// Reset clears all move state and loads the default configuration at once.
// ----------------------------------------------------------------------------
module stepper_trapezoid_ramp (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [stramp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [stramp_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    command,
    input  logic signed [stramp_pkg::STEP_BITS-1:0] move_steps,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [stramp_pkg::INC_W-1:0]            compare_increment,
    output logic                                    direction,
    output logic [1:0]                              phase,
    output logic                                    timer_enable,
    output logic                                    pulse_done
);
    import stramp_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    stramp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    stramp_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .command           (command),
        .move_steps        (move_steps),
        .cmd               (cmd),
        .status            (status),
        .compare_increment (compare_increment),
        .direction         (direction),
        .phase             (phase),
        .timer_enable      (timer_enable),
        .pulse_done        (pulse_done)
    );

    // Work on an item blocks the input until its result is registered.
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready
    ) else $error("input accepted while an item is in flight");

    // The timer runs exactly when the profile is not stopped.
    a_stop_matches_timer: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> ((phase == PH_STOP) == !timer_enable)
    ) else $error("stop phase and timer enable disagree");

    // The divider only runs on behalf of an accepted item.
    a_div_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        status.div_busy |-> !in_ready
    ) else $error("divider busy while the block is idle");

endmodule
